FILE: design/qphm_pkg.sv
// ----------------------------------------------------------------------------
// qphm_pkg
// Shared types, field widths and codes for the quadratic-probe hash map.
// ----------------------------------------------------------------------------
package qphm_pkg;

	// Field widths
	localparam int OP_W   = 2;
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int SLOT_W = 9;
	localparam int ST_W   = 2;

	// Hash: (key & 0x7FFFFFF8) >> 2 keeps 28 significant bits (bit 0 is zero)
	localparam logic [KEY_W-1:0] HASH_MASK = 32'h7FFF_FFF8;
	localparam int               H_W       = 29;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NEXT   = 2'd3;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
	localparam logic [ST_W-1:0] ST_LIMIT  = 2'd3;

	// Reserved keys
	localparam logic [KEY_W-1:0] KEY_EMPTY = 32'd0;
	localparam logic [KEY_W-1:0] KEY_TOMB  = 32'd1;

	// Result kinds the controller asks the datapath to record
	localparam logic [2:0] RES_OK     = 3'd0;
	localparam logic [2:0] RES_ABSENT = 3'd1;
	localparam logic [2:0] RES_FULL   = 3'd2;
	localparam logic [2:0] RES_LIMIT  = 3'd3;
	localparam logic [2:0] RES_VALUE  = 3'd4;
	localparam logic [2:0] RES_SLOT   = 3'd5;

	// Controller -> datapath commands
	typedef struct packed {
		logic       clr_wr;     // clearing pass: write one empty slot
		logic       load;       // capture accepted transaction
		logic       home_step;  // one step of the home-slot reduction
		logic       scan_adv;   // scan moves to the following slot
		logic       probe_adv;  // probe moves to the next quadratic slot
		logic       wr_upd;     // overwrite value at a hit
		logic       wr_new;     // insert key and value in an empty slot
		logic       wr_tomb;    // turn the hit slot into a tombstone
		logic       res_set;    // record result of the transaction
		logic [2:0] res_code;
		logic       out_load;   // move recorded result to output register
	} dp_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic            clr_last;
		logic            in_next;
		logic            in_reserved;
		logic            in_oob;
		logic            home_done;
		logic [OP_W-1:0] op;
		logic            hit;
		logic            empty;
		logic            live;
		logic            probe_last;
		logic            scan_last;
		logic            full;
		logic            out_free;
	} dp_stat_t;

endpackage

FILE: design/qphm_datapath.sv
// ----------------------------------------------------------------------------
// qphm_datapath
// Key/value memories, probe address arithmetic, counters and result register.
// ----------------------------------------------------------------------------
module qphm_datapath #(
	parameter int SLOTS = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  qphm_pkg::dp_cmd_t         cmd,
	output qphm_pkg::dp_stat_t        stat,
	input  logic [qphm_pkg::OP_W-1:0]   op,
	input  logic [qphm_pkg::KEY_W-1:0]  key,
	input  logic [qphm_pkg::VAL_W-1:0]  value_in,
	input  logic [qphm_pkg::SLOT_W-1:0] start_slot,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [qphm_pkg::VAL_W-1:0]  value_out,
	output logic [qphm_pkg::ST_W-1:0]   status,
	output logic [qphm_pkg::SLOT_W-1:0] next_slot,
	output logic [qphm_pkg::SLOT_W-1:0] deleted_total
);
	import qphm_pkg::*;

	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int HOME_STEPS = 2;
	localparam int HC_W       = $clog2(HOME_STEPS + 1);
	localparam bit IS_POW2    = (SLOTS & (SLOTS - 1)) == 0;

	// Reciprocal for the home-slot remainder: ceil(2^(H_W+IDX_W) / SLOTS),
	// exact quotient for every H_W-bit hash
	localparam int               RC_SH   = H_W + IDX_W;
	localparam int               RC_W    = H_W + 1;
	localparam int               PR_W    = H_W + RC_W;
	localparam int               QT_W    = PR_W - RC_SH;
	localparam logic [63:0]      RC_ONE  = 64'd1 << RC_SH;
	localparam logic [63:0]      RC_FULL = (RC_ONE + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
	localparam logic [RC_W-1:0]  RECIP   = RC_FULL[RC_W-1:0];
	localparam logic [H_W-1:0]   SLOTS_H = H_W'(SLOTS);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W+1:0] SLOTS_S  = (IDX_W + 2)'(SLOTS);
	localparam logic [IDX_W+1:0] STEP_BASE = (IDX_W + 2)'(8);
	localparam logic [HC_W-1:0]  HC_LAST  = HC_W'(HOME_STEPS);
	localparam logic [31:0]      FULL_LIM = 32'(3 * SLOTS);

	// Memories
	logic [KEY_W-1:0] key_mem [SLOTS];
	logic [VAL_W-1:0] val_mem [SLOTS];

	// Transaction registers
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [H_W-1:0]   h_q;
	logic [HC_W-1:0]  hcnt_q;
	logic [PR_W-1:0]  prod_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] n_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;

	// Control registers
	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] ins_q;
	logic [CNT_W-1:0] tomb_q;
	logic             out_valid_q;

	// Recorded result and output register
	logic [ST_W-1:0]   res_status_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [VAL_W-1:0]  value_out_q;
	logic [ST_W-1:0]   status_q;
	logic [SLOT_W-1:0] next_slot_q;
	logic [SLOT_W-1:0] deleted_q;

	// Combinational helpers
	logic [KEY_W-1:0] h_full;
	logic [QT_W-1:0]  quo;
	logic [H_W-1:0]   rem_full;
	logic [IDX_W+1:0] step_sum;
	logic [IDX_W+1:0] step_r1;
	logic [IDX_W+1:0] step_r2;
	logic [IDX_W:0]   slot_plus;
	logic             mem_we;
	logic             key_we;
	logic [IDX_W-1:0] wr_addr;
	logic [KEY_W-1:0] wr_key;
	logic [VAL_W-1:0] wr_val;

	// Hash of the incoming key
	assign h_full = (key & HASH_MASK) >> 2;

	// Home-slot remainder from the registered reciprocal product (non power-of-two table)
	always_comb begin
		quo      = prod_q[PR_W-1:RC_SH];
		rem_full = h_q - H_W'(quo) * SLOTS_H;
	end

	// Quadratic step: slot + 8 + n, wrapped; sum stays below 3 * SLOTS
	always_comb begin
		step_sum = (IDX_W + 2)'(slot_q) + (IDX_W + 2)'(n_q) + STEP_BASE;
		step_r1  = (step_sum >= SLOTS_S) ? step_sum - SLOTS_S : step_sum;
		step_r2  = (step_r1 >= SLOTS_S) ? step_r1 - SLOTS_S : step_r1;
	end

	assign slot_plus = {1'b0, slot_q} + (IDX_W + 1)'(1);

	// Memory write port
	always_comb begin
		mem_we  = cmd.clr_wr | cmd.wr_upd | cmd.wr_new | cmd.wr_tomb;
		key_we  = cmd.clr_wr | cmd.wr_new | cmd.wr_tomb;
		wr_addr = cmd.clr_wr ? clr_q : slot_q;
		wr_key  = KEY_EMPTY;
		wr_val  = '0;
		if (cmd.wr_tomb) begin
			wr_key = KEY_TOMB;
		end else if (cmd.wr_new || cmd.wr_upd) begin
			wr_key = key_q;
			wr_val = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			val_mem[wr_addr] <= wr_val;
		end
		if (key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		rd_key_q <= key_mem[slot_q];
		rd_val_q <= val_mem[slot_q];
	end

	// Control state: clearing pass, counters, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			ins_q       <= '0;
			tomb_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.wr_new) begin
				ins_q <= ins_q + CNT_W'(1);
			end
			if (cmd.wr_tomb) begin
				tomb_q <= tomb_q + CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction and probe registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			key_q  <= key;
			val_q  <= value_in;
			h_q    <= h_full[H_W-1:0];
			hcnt_q <= '0;
			n_q    <= '0;
			if (op == OP_NEXT) begin
				slot_q <= IDX_W'(start_slot);
			end else if (IS_POW2) begin
				slot_q <= IDX_W'(h_full);
			end else begin
				slot_q <= '0;
			end
		end else if (cmd.home_step) begin
			// first step multiplies by the reciprocal, second takes the remainder
			if (hcnt_q == '0) begin
				prod_q <= PR_W'(h_q) * PR_W'(RECIP);
			end else begin
				slot_q <= IDX_W'(rem_full);
			end
			hcnt_q <= hcnt_q + HC_W'(1);
		end else if (cmd.probe_adv) begin
			slot_q <= IDX_W'(step_r2);
			n_q    <= n_q + IDX_W'(1);
		end else if (cmd.scan_adv) begin
			slot_q <= slot_q + IDX_W'(1);
		end
	end

	// Recorded result
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_val_q  <= '0;
			res_slot_q <= '0;
			case (cmd.res_code)
				RES_OK: begin
					res_status_q <= ST_OK;
				end
				RES_ABSENT: begin
					res_status_q <= ST_ABSENT;
				end
				RES_FULL: begin
					res_status_q <= ST_FULL;
				end
				RES_LIMIT: begin
					res_status_q <= ST_LIMIT;
				end
				RES_VALUE: begin
					res_status_q <= ST_OK;
					res_val_q    <= rd_val_q;
				end
				RES_SLOT: begin
					res_status_q <= ST_OK;
					res_slot_q   <= SLOT_W'(slot_plus);
				end
				default: begin
					res_status_q <= ST_ABSENT;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			value_out_q <= res_val_q;
			status_q    <= res_status_q;
			next_slot_q <= res_slot_q;
			deleted_q   <= SLOT_W'(tomb_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign value_out     = value_out_q;
	assign status        = status_q;
	assign next_slot     = next_slot_q;
	assign deleted_total = deleted_q;

	// Status to controller
	always_comb begin
		stat.clr_last    = clr_q == LAST_IDX;
		stat.in_next     = op == OP_NEXT;
		stat.in_reserved = key[KEY_W-1:1] == '0;
		stat.in_oob      = 32'(start_slot) >= 32'(SLOTS);
		stat.home_done   = IS_POW2 || (hcnt_q == HC_LAST);
		stat.op          = op_q;
		stat.hit         = rd_key_q == key_q;
		stat.empty       = rd_key_q == KEY_EMPTY;
		stat.live        = rd_key_q > KEY_TOMB;
		stat.probe_last  = n_q == LAST_IDX;
		stat.scan_last   = slot_q == LAST_IDX;
		stat.full        = (32'(ins_q) << 3) > FULL_LIM;
		stat.out_free    = !out_valid_q || out_ready;
	end

endmodule

FILE: design/qphm_ctrl.sv
// ----------------------------------------------------------------------------
// qphm_ctrl
// Sequencer for clearing, home-slot reduction, probing, scanning and results.
// ----------------------------------------------------------------------------
module qphm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qphm_pkg::dp_stat_t stat,
	output qphm_pkg::dp_cmd_t  cmd
);
	import qphm_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HOME  = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_ready = state_q == S_IDLE;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (stat.in_next) begin
						if (stat.in_oob) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = RES_ABSENT;
							state_nxt    = S_FIN;
						end else begin
							state_nxt = S_RD;
						end
					end else if (stat.in_reserved) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = RES_ABSENT;
						state_nxt    = S_FIN;
					end else begin
						state_nxt = S_HOME;
					end
				end
			end
			S_HOME: begin
				if (stat.home_done) begin
					state_nxt = S_RD;
				end else begin
					cmd.home_step = 1'b1;
				end
			end
			S_RD: begin
				state_nxt = S_CHK;
			end
			S_CHK: begin
				if (stat.op == OP_NEXT) begin
					// scan for a live slot
					if (stat.live) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = RES_SLOT;
						state_nxt    = S_FIN;
					end else if (stat.scan_last) begin
						cmd.res_set  = 1'b1;
						cmd.res_code = RES_ABSENT;
						state_nxt    = S_FIN;
					end else begin
						cmd.scan_adv = 1'b1;
						state_nxt    = S_RD;
					end
				end else if (stat.hit) begin
					cmd.res_set = 1'b1;
					state_nxt   = S_FIN;
					if (stat.op == OP_PUT) begin
						cmd.wr_upd   = 1'b1;
						cmd.res_code = RES_OK;
					end else if (stat.op == OP_REMOVE) begin
						cmd.wr_tomb  = 1'b1;
						cmd.res_code = RES_VALUE;
					end else begin
						cmd.res_code = RES_VALUE;
					end
				end else if (stat.empty) begin
					cmd.res_set = 1'b1;
					state_nxt   = S_FIN;
					if (stat.op != OP_PUT) begin
						cmd.res_code = RES_ABSENT;
					end else if (stat.full) begin
						cmd.res_code = RES_FULL;
					end else begin
						cmd.wr_new   = 1'b1;
						cmd.res_code = RES_OK;
					end
				end else if (stat.probe_last) begin
					cmd.res_set  = 1'b1;
					cmd.res_code = RES_LIMIT;
					state_nxt    = S_FIN;
				end else begin
					cmd.probe_adv = 1'b1;
					state_nxt     = S_RD;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: design/quadratic_probe_hash_map_unit.sv
// Sequence: put, get and remove pass the home-slot reduction (multiply, then remainder,
//   unless SLOTS is a power of two), a scan starts at start_slot, and each then reads and
//   checks slots until one decides; a reserved key or out-of-range scan start skips both.
// Throughput: one transaction at a time; the next is accepted the cycle after the result
//   is loaded, and a held result stalls the sequencer until the output register frees.
// Reset: a clearing pass writes every slot empty, with in_ready low throughout.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_map_unit
// Open-addressed key/value map with quadratic probing, tombstones and a scan.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_map_unit #(
	parameter int SLOTS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [qphm_pkg::OP_W-1:0]   op,
	input  logic [qphm_pkg::KEY_W-1:0]  key,
	input  logic [qphm_pkg::VAL_W-1:0]  value_in,
	input  logic [qphm_pkg::SLOT_W-1:0] start_slot,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [qphm_pkg::VAL_W-1:0]  value_out,
	output logic [qphm_pkg::ST_W-1:0]   status,
	output logic [qphm_pkg::SLOT_W-1:0] next_slot,
	output logic [qphm_pkg::SLOT_W-1:0] deleted_total
);
	import qphm_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer
	qphm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Memories and arithmetic
	qphm_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (op),
		.key           (key),
		.value_in      (value_in),
		.start_slot    (start_slot),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.value_out     (value_out),
		.status        (status),
		.next_slot     (next_slot),
		.deleted_total (deleted_total)
	);

endmodule
